// ===== rtl/core/bpa_pkg.sv =====
// Shared types, codes and constants of the buddy page allocator.
package bpa_pkg;

    localparam int PAGE_W    = 20;
    localparam int COUNT_W   = 11;
    localparam int ORDER_W   = 4;
    localparam int MAX_ORDER = 11;
    localparam int MAX_PAGES = 1 << (MAX_ORDER - 1);

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_SEED  = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BYPASS   = 3'd1,
        ST_NOBLOCK  = 3'd2,
        ST_INVALID  = 3'd3,
        ST_DISABLED = 3'd4,
        ST_POOLFULL = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_POP,
        S_SPLIT,
        S_PUSH_RD,
        S_PUSH_WR,
        S_MERGE,
        S_WALK_RD,
        S_WALK_CHK,
        S_GIVE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [PAGE_W-1:0]  page_index;
        logic [COUNT_W-1:0] page_count;
        logic [ORDER_W-1:0] seed_order;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [PAGE_W-1:0]  result_page;
        logic [ORDER_W-1:0] result_order;
    } out_word_t;

    // Smallest order whose block holds count pages, capped at the top order.
    function automatic logic [ORDER_W-1:0] order_of(input logic [COUNT_W-1:0] count);
        logic [ORDER_W-1:0] o;
        o = ORDER_W'(MAX_ORDER - 1);
        for (int i = MAX_ORDER - 2; i >= 0; i--) begin
            if (count <= (COUNT_W'(1) << i)) begin
                o = ORDER_W'(i);
            end
        end
        return o;
    endfunction

    function automatic logic aligned(input logic [PAGE_W-1:0] page,
                                     input logic [ORDER_W-1:0] o);
        return (page & ((PAGE_W'(1) << o) - PAGE_W'(1))) == '0;
    endfunction

endpackage

// ===== rtl/core/bpa_node_mem.sv =====
// Node pool storage: page and link memories with registered read.
module bpa_node_mem #(
    parameter int POOL_NODES = 1024,
    localparam int AW = $clog2(POOL_NODES),
    localparam int LW = $clog2(POOL_NODES + 1)
) (
    input  logic                      aclk,
    input  logic [AW-1:0]             rd_addr,
    input  logic [AW-1:0]             wr_addr,
    input  logic                      page_we,
    input  logic                      link_we,
    input  logic [bpa_pkg::PAGE_W-1:0] page_wdata,
    input  logic [LW-1:0]             link_wdata,
    output logic [bpa_pkg::PAGE_W-1:0] rd_page,
    output logic [LW-1:0]             rd_link
);

    logic [bpa_pkg::PAGE_W-1:0] page_mem [POOL_NODES];
    logic [LW-1:0]              link_mem [POOL_NODES];

    always_ff @(posedge aclk) begin
        if (page_we) begin
            page_mem[wr_addr] <= page_wdata;
        end
        rd_page <= page_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[wr_addr] <= link_wdata;
        end
        rd_link <= link_mem[rd_addr];
    end

endmodule

// ===== rtl/core/bpa_ctrl.sv =====
// Sequencer: free-list heads, node pool chain and the alloc/free/seed walks.
module bpa_ctrl #(
    parameter int POOL_NODES = 1024,
    localparam int AW = $clog2(POOL_NODES),
    localparam int LW = $clog2(POOL_NODES + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                enabled,
    input  logic                in_valid,
    output logic                in_ready,
    input  bpa_pkg::in_word_t   in_word,
    output logic                done_valid,
    input  logic                done_ready,
    output bpa_pkg::out_word_t  done_word
);

    localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

    bpa_pkg::state_t  state_reg, state_next;
    bpa_pkg::cmd_t    cmd_reg, cmd_next;
    bpa_pkg::status_t status_reg, status_next;
    logic [bpa_pkg::PAGE_W-1:0]  page_reg, page_next;
    logic [bpa_pkg::PAGE_W-1:0]  bud_reg, bud_next;
    logic [bpa_pkg::ORDER_W-1:0] ord_reg, ord_next;
    logic [bpa_pkg::ORDER_W-1:0] want_reg, want_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] prev_reg, prev_next;
    logic [LW-1:0] pool_head_reg, pool_head_next;
    logic [LW-1:0] fresh_reg, fresh_next;
    logic [LW-1:0] head_reg [bpa_pkg::MAX_ORDER];
    logic [LW-1:0] head_next [bpa_pkg::MAX_ORDER];

    logic [AW-1:0] rd_addr, wr_addr;
    logic          page_we, link_we;
    logic [bpa_pkg::PAGE_W-1:0] page_wdata, rd_page;
    logic [LW-1:0] link_wdata, rd_link;
    logic [LW-1:0] head_sel;
    logic [LW-1:0] eff_link;
    logic [LW-1:0] eff_node;
    logic [bpa_pkg::ORDER_W-1:0] in_ord;
    logic [bpa_pkg::PAGE_W-1:0]  push_page;
    logic ord_in_range;

    bpa_node_mem #(.POOL_NODES(POOL_NODES)) u_mem (
        .aclk       (aclk),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .page_we    (page_we),
        .link_we    (link_we),
        .page_wdata (page_wdata),
        .link_wdata (link_wdata),
        .rd_page    (rd_page),
        .rd_link    (rd_link)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bpa_pkg::S_IDLE;
            pool_head_reg <= '0;
            fresh_reg     <= '0;
            for (int i = 0; i < bpa_pkg::MAX_ORDER; i++) begin
                head_reg[i] <= NIL;
            end
        end else begin
            state_reg     <= state_next;
            pool_head_reg <= pool_head_next;
            fresh_reg     <= fresh_next;
            for (int i = 0; i < bpa_pkg::MAX_ORDER; i++) begin
                head_reg[i] <= head_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        page_reg   <= page_next;
        bud_reg    <= bud_next;
        ord_reg    <= ord_next;
        want_reg   <= want_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
    end

    assign ord_in_range = ord_reg < bpa_pkg::ORDER_W'(bpa_pkg::MAX_ORDER);
    assign head_sel  = ord_in_range ? head_reg[ord_reg[bpa_pkg::ORDER_W-1:0]] : NIL;
    assign in_ord    = bpa_pkg::order_of(in_word.page_count);
    assign push_page = (cmd_reg == bpa_pkg::CMD_ALLOC) ? bud_reg : page_reg;

    // Nodes at or above the fresh mark were never taken: their link is still n+1.
    assign eff_node = (state_reg == bpa_pkg::S_POP) ? cur_reg :
                      (state_reg == bpa_pkg::S_PUSH_WR) ? pool_head_reg : cur_reg;
    assign eff_link = (eff_node >= fresh_reg) ? (eff_node + LW'(1)) : rd_link;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        status_next    = status_reg;
        page_next      = page_reg;
        bud_next       = bud_reg;
        ord_next       = ord_reg;
        want_next      = want_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        pool_head_next = pool_head_reg;
        fresh_next     = fresh_reg;
        for (int i = 0; i < bpa_pkg::MAX_ORDER; i++) begin
            head_next[i] = head_reg[i];
        end
        rd_addr    = cur_reg[AW-1:0];
        wr_addr    = cur_reg[AW-1:0];
        page_we    = 1'b0;
        link_we    = 1'b0;
        page_wdata = push_page;
        link_wdata = pool_head_reg;
        in_ready   = 1'b0;
        done_valid = 1'b0;

        unique case (state_reg)
            bpa_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_next    = bpa_pkg::cmd_t'(in_word.command);
                    page_next   = in_word.page_index;
                    ord_next    = in_ord;
                    want_next   = in_ord;
                    status_next = bpa_pkg::ST_OK;
                    state_next  = bpa_pkg::S_DONE;
                    if (!enabled) begin
                        status_next = bpa_pkg::ST_DISABLED;
                    end else if (in_word.command == bpa_pkg::CMD_ALLOC ||
                                 in_word.command == bpa_pkg::CMD_FREE) begin
                        if (in_word.page_count == '0 ||
                            in_word.page_count > bpa_pkg::COUNT_W'(bpa_pkg::MAX_PAGES)) begin
                            status_next = bpa_pkg::ST_INVALID;
                        end else if (in_word.page_count == bpa_pkg::COUNT_W'(1)) begin
                            status_next = bpa_pkg::ST_BYPASS;
                        end else if (in_word.command == bpa_pkg::CMD_ALLOC) begin
                            state_next = bpa_pkg::S_SEARCH;
                        end else if (!bpa_pkg::aligned(in_word.page_index, in_ord)) begin
                            status_next = bpa_pkg::ST_INVALID;
                        end else begin
                            state_next = bpa_pkg::S_MERGE;
                        end
                    end else if (in_word.command == bpa_pkg::CMD_SEED) begin
                        ord_next = in_word.seed_order;
                        if (in_word.seed_order >= bpa_pkg::ORDER_W'(bpa_pkg::MAX_ORDER) ||
                            !bpa_pkg::aligned(in_word.page_index, in_word.seed_order)) begin
                            status_next = bpa_pkg::ST_INVALID;
                        end else begin
                            state_next = bpa_pkg::S_PUSH_RD;
                        end
                    end else begin
                        status_next = bpa_pkg::ST_INVALID;
                    end
                end
            end

            // Scan orders upward; issue the read of the first non-empty head, or report no block past the top order.
            bpa_pkg::S_SEARCH: begin
                if (!ord_in_range) begin
                    status_next = bpa_pkg::ST_NOBLOCK;
                    state_next  = bpa_pkg::S_DONE;
                end else if (head_sel == NIL) begin
                    ord_next = ord_reg + bpa_pkg::ORDER_W'(1);
                end else begin
                    cur_next   = head_sel;
                    rd_addr    = head_sel[AW-1:0];
                    state_next = bpa_pkg::S_POP;
                end
            end

            // Unlink the head node and hand it back to the pool.
            bpa_pkg::S_POP: begin
                head_next[ord_reg] = eff_link;
                page_next          = rd_page;
                wr_addr            = cur_reg[AW-1:0];
                link_we            = 1'b1;
                link_wdata         = pool_head_reg;
                pool_head_next     = cur_reg;
                state_next         = bpa_pkg::S_SPLIT;
            end

            bpa_pkg::S_SPLIT: begin
                if (ord_reg == want_reg) begin
                    state_next = bpa_pkg::S_DONE;
                end else begin
                    ord_next   = ord_reg - bpa_pkg::ORDER_W'(1);
                    bud_next   = page_reg ^ (bpa_pkg::PAGE_W'(1) <<
                                             (ord_reg - bpa_pkg::ORDER_W'(1)));
                    state_next = bpa_pkg::S_PUSH_RD;
                end
            end

            bpa_pkg::S_PUSH_RD: begin
                if (pool_head_reg == NIL) begin
                    status_next = bpa_pkg::ST_POOLFULL;
                    state_next  = (cmd_reg == bpa_pkg::CMD_ALLOC) ? bpa_pkg::S_SPLIT
                                                                   : bpa_pkg::S_DONE;
                end else begin
                    rd_addr    = pool_head_reg[AW-1:0];
                    state_next = bpa_pkg::S_PUSH_WR;
                end
            end

            // Take the pool head, fill it and link it onto the order's list.
            bpa_pkg::S_PUSH_WR: begin
                pool_head_next = eff_link;
                if (pool_head_reg >= fresh_reg) begin
                    fresh_next = fresh_reg + LW'(1);
                end
                wr_addr            = pool_head_reg[AW-1:0];
                page_we            = 1'b1;
                link_we            = 1'b1;
                page_wdata         = push_page;
                link_wdata         = head_sel;
                head_next[ord_reg] = pool_head_reg;
                state_next = (cmd_reg == bpa_pkg::CMD_ALLOC) ? bpa_pkg::S_SPLIT
                                                              : bpa_pkg::S_DONE;
            end

            bpa_pkg::S_MERGE: begin
                if (ord_reg >= bpa_pkg::ORDER_W'(bpa_pkg::MAX_ORDER - 1)) begin
                    state_next = bpa_pkg::S_PUSH_RD;
                end else begin
                    bud_next   = page_reg ^ (bpa_pkg::PAGE_W'(1) << ord_reg);
                    cur_next   = head_sel;
                    prev_next  = NIL;
                    state_next = bpa_pkg::S_WALK_RD;
                end
            end

            bpa_pkg::S_WALK_RD: begin
                if (cur_reg == NIL) begin
                    state_next = bpa_pkg::S_PUSH_RD;
                end else begin
                    rd_addr    = cur_reg[AW-1:0];
                    state_next = bpa_pkg::S_WALK_CHK;
                end
            end

            bpa_pkg::S_WALK_CHK: begin
                if (rd_page == bud_reg) begin
                    if (prev_reg == NIL) begin
                        head_next[ord_reg] = eff_link;
                    end else begin
                        wr_addr    = prev_reg[AW-1:0];
                        link_we    = 1'b1;
                        link_wdata = eff_link;
                    end
                    state_next = bpa_pkg::S_GIVE;
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = eff_link;
                    state_next = bpa_pkg::S_WALK_RD;
                end
            end

            // Return the buddy's node to the pool and climb one order.
            bpa_pkg::S_GIVE: begin
                wr_addr        = cur_reg[AW-1:0];
                link_we        = 1'b1;
                link_wdata     = pool_head_reg;
                pool_head_next = cur_reg;
                if (bud_reg < page_reg) begin
                    page_next = bud_reg;
                end
                ord_next   = ord_reg + bpa_pkg::ORDER_W'(1);
                state_next = bpa_pkg::S_MERGE;
            end

            bpa_pkg::S_DONE: begin
                done_valid = 1'b1;
                if (done_ready) begin
                    state_next = bpa_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        done_word.status = status_reg;
        if (status_reg == bpa_pkg::ST_OK || status_reg == bpa_pkg::ST_POOLFULL) begin
            done_word.result_page  = page_reg;
            done_word.result_order = ord_reg;
        end else begin
            done_word.result_page  = '0;
            done_word.result_order = '0;
        end
    end

endmodule

// ===== rtl/core/buddy_page_allocator_core.sv =====
// Top level of the buddy page allocator: enable register, sequencer and output register.
//
// Usage: a request word enters on s_valid/s_ready (command, page_index, page_count,
// seed_order) and exactly one result word leaves on m_valid/m_ready (status,
// result_page, result_order). Write cfg_wdata with cfg_we high to set the enable bit;
// while it is low every request returns status disabled.
// Sequencing: a rejected, bypass or invalid request goes straight to the done state. A
// seed reads the pool head and writes the node. An allocate scans orders upward, pops,
// and per split does a pool read, a node write and an order step. A free reads and checks
// each list node visited while hunting each buddy, returns the buddy's node per merge
// step and ends with a final push; its cost grows with the free list lengths. One
// request is in the sequencer at a time; s_ready is high only while it is idle.
// Reset leaves every order list empty, the node pool chained from node 0 and the
// allocator disabled; no clearing pass is needed, nodes never taken are tracked by a
// fill mark. When the receiver stalls the result is held in the output register and
// the sequencer can take the next request, finishing it into a wait until the
// register frees.
module buddy_page_allocator_core #(
    parameter int POOL_NODES = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bpa_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bpa_pkg::out_word_t  m_data,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    logic               enabled_reg;
    logic               m_valid_reg;
    bpa_pkg::out_word_t m_data_reg;
    logic               done_valid, done_ready;
    bpa_pkg::out_word_t done_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
        end else if (cfg_we) begin
            enabled_reg <= cfg_wdata;
        end
    end

    bpa_ctrl #(.POOL_NODES(POOL_NODES)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .enabled    (enabled_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_word    (s_data),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .done_word  (done_word)
    );

    assign done_ready = !m_valid_reg || m_ready;

    // Load a finished word when the slot is empty or being drained.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done_ready) begin
            m_valid_reg <= done_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_valid && done_ready) begin
            m_data_reg <= done_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the buddy page allocator core: directed and random requests.
module tb_top;

    localparam int POOL = 1024;
    localparam int NIL  = POOL;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    bpa_pkg::in_word_t   s_data;
    logic                m_valid;
    logic                m_ready;
    bpa_pkg::out_word_t  m_data;
    logic                cfg_we;
    logic                cfg_wdata;

    buddy_page_allocator_core #(.POOL_NODES(POOL)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0; #2;
        aclk = 1'b1; #2;
    end

    // Shadow allocator state
    logic [bpa_pkg::PAGE_W-1:0] sh_page [POOL];
    int                         sh_link [POOL];
    int                         sh_head [bpa_pkg::MAX_ORDER];
    int                         sh_pool;
    bit                         sh_enabled;

    bpa_pkg::out_word_t expected_q[$];
    int  fail_count;
    int  result_count;
    int  status_seen [6];
    bit  quiet_mode;     // no idling in the final stretch
    bit  hold_off;       // long receiver stall
    bit  valid_hi;       // sender is currently driving s_valid high

    function automatic int take_node();
        int n;
        n = sh_pool;
        if (n >= NIL) return NIL;
        sh_pool = sh_link[n];
        return n;
    endfunction

    function automatic void give_node(int n);
        sh_link[n] = sh_pool;
        sh_pool = n;
    endfunction

    function automatic bit push_block(int o, logic [bpa_pkg::PAGE_W-1:0] pg);
        int n;
        n = take_node();
        if (n >= NIL) return 1'b0;
        sh_page[n] = pg;
        sh_link[n] = sh_head[o];
        sh_head[o] = n;
        return 1'b1;
    endfunction

    function automatic bit pop_block(int o, output logic [bpa_pkg::PAGE_W-1:0] pg);
        int n;
        n = sh_head[o];
        pg = '0;
        if (n >= NIL) return 1'b0;
        sh_head[o] = sh_link[n];
        pg = sh_page[n];
        give_node(n);
        return 1'b1;
    endfunction

    function automatic bit unlink_block(int o, logic [bpa_pkg::PAGE_W-1:0] pg);
        int prev;
        int cur;
        prev = NIL;
        cur = sh_head[o];
        while (cur < NIL) begin
            if (sh_page[cur] == pg) begin
                if (prev >= NIL) sh_head[o] = sh_link[cur];
                else sh_link[prev] = sh_link[cur];
                give_node(cur);
                return 1'b1;
            end
            prev = cur;
            cur = sh_link[cur];
        end
        return 1'b0;
    endfunction

    function automatic int count_order(int count);
        int o;
        o = 0;
        while (o < bpa_pkg::MAX_ORDER - 1 && (1 << o) < count) o++;
        return o;
    endfunction

    function automatic bit is_aligned(logic [bpa_pkg::PAGE_W-1:0] pg, int o);
        return (pg & ((bpa_pkg::PAGE_W'(1) << o) - 1)) == 0;
    endfunction

    function automatic bpa_pkg::out_word_t predict_result(bpa_pkg::in_word_t w);
        bpa_pkg::out_word_t r;
        int o;
        int want;
        logic [bpa_pkg::PAGE_W-1:0] blk;
        logic [bpa_pkg::PAGE_W-1:0] bud;
        logic [bpa_pkg::PAGE_W-1:0] pg;
        r = '0;
        r.status = bpa_pkg::ST_OK;
        pg = w.page_index;
        if (!sh_enabled) begin
            r.status = bpa_pkg::ST_DISABLED;
        end else if (w.command == bpa_pkg::CMD_ALLOC || w.command == bpa_pkg::CMD_FREE) begin
            if (w.page_count == 0 || w.page_count > bpa_pkg::MAX_PAGES) begin
                r.status = bpa_pkg::ST_INVALID;
            end else if (w.page_count == 1) begin
                r.status = bpa_pkg::ST_BYPASS;
            end else if (w.command == bpa_pkg::CMD_ALLOC) begin
                want = count_order(w.page_count);
                o = want;
                while (o < bpa_pkg::MAX_ORDER && !pop_block(o, blk)) o++;
                if (o >= bpa_pkg::MAX_ORDER) begin
                    r.status = bpa_pkg::ST_NOBLOCK;
                end else begin
                    for (; o > want; o--) begin
                        bud = blk ^ (bpa_pkg::PAGE_W'(1) << (o - 1));
                        if (!push_block(o - 1, bud)) r.status = bpa_pkg::ST_POOLFULL;
                    end
                    r.result_page = blk;
                    r.result_order = bpa_pkg::ORDER_W'(want);
                end
            end else begin
                o = count_order(w.page_count);
                if (!is_aligned(pg, o)) begin
                    r.status = bpa_pkg::ST_INVALID;
                end else begin
                    while (o < bpa_pkg::MAX_ORDER - 1) begin
                        bud = pg ^ (bpa_pkg::PAGE_W'(1) << o);
                        if (!unlink_block(o, bud)) break;
                        if (bud < pg) pg = bud;
                        o++;
                    end
                    if (!push_block(o, pg)) r.status = bpa_pkg::ST_POOLFULL;
                    r.result_page = pg;
                    r.result_order = bpa_pkg::ORDER_W'(o);
                end
            end
        end else if (w.command == bpa_pkg::CMD_SEED) begin
            if (w.seed_order >= bpa_pkg::MAX_ORDER || !is_aligned(pg, w.seed_order)) begin
                r.status = bpa_pkg::ST_INVALID;
            end else begin
                if (!push_block(w.seed_order, pg)) r.status = bpa_pkg::ST_POOLFULL;
                r.result_page = pg;
                r.result_order = w.seed_order;
            end
        end else begin
            r.status = bpa_pkg::ST_INVALID;
        end
        return r;
    endfunction

    // Lower s_valid once; the next word raises it again.
    task automatic drop_valid();
        if (valid_hi) begin
            s_valid <= 1'b0;
            valid_hi = 1'b0;
        end
    endtask

    task automatic idle_burst();
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            drop_valid();
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic send_word(bpa_pkg::in_word_t w);
        s_data <= w;
        if (!valid_hi) begin
            s_valid <= 1'b1;
            valid_hi = 1'b1;
        end
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(predict_result(w));
        idle_burst();
    endtask

    function automatic bpa_pkg::in_word_t make_word(bpa_pkg::cmd_t c, int pg, int cnt, int so);
        bpa_pkg::in_word_t w;
        w.command = c;
        w.page_index = bpa_pkg::PAGE_W'(pg);
        w.page_count = bpa_pkg::COUNT_W'(cnt);
        w.seed_order = bpa_pkg::ORDER_W'(so);
        return w;
    endfunction

    task automatic write_enable(bit v);
        drop_valid();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sh_enabled = v;
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        bpa_pkg::out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: %p", m_data);
                fail_count++;
            end else begin
                e = expected_q.pop_front();
                if (e.status <= 5) status_seen[e.status]++;
                if (m_data.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, m_data.status);
                    fail_count++;
                end
                if (m_data.result_page !== e.result_page) begin
                    $error("result_page expected %0h actual %0h",
                           e.result_page, m_data.result_page);
                    fail_count++;
                end
                if (m_data.result_order !== e.result_order) begin
                    $error("result_order expected %0d actual %0d",
                           e.result_order, m_data.result_order);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_disabled();
        send_word(make_word(bpa_pkg::CMD_ALLOC, 0, 4, 0));
        send_word(make_word(bpa_pkg::CMD_SEED, 0, 0, 3));
        send_word(make_word(bpa_pkg::CMD_RSVD, 'hFFFFF, 'h7FF, 15));
    endtask

    task automatic test_directed();
        write_enable(1'b1);
        send_word(make_word(bpa_pkg::CMD_RSVD, 0, 2, 0));
        send_word(make_word(bpa_pkg::CMD_ALLOC, 0, 0, 0));
        send_word(make_word(bpa_pkg::CMD_FREE, 0, 1, 0));
        send_word(make_word(bpa_pkg::CMD_ALLOC, 0, 1, 0));
        send_word(make_word(bpa_pkg::CMD_ALLOC, 0, 1025, 0));
        send_word(make_word(bpa_pkg::CMD_ALLOC, 0, 'h7FF, 0));
        send_word(make_word(bpa_pkg::CMD_ALLOC, 0, 2, 0));        // no block
        send_word(make_word(bpa_pkg::CMD_SEED, 3, 0, 1));         // misaligned
        send_word(make_word(bpa_pkg::CMD_SEED, 0, 0, 11));        // order too big
        send_word(make_word(bpa_pkg::CMD_SEED, 0, 0, 15));
        send_word(make_word(bpa_pkg::CMD_SEED, 0, 0, 10));        // page zero, top order
        send_word(make_word(bpa_pkg::CMD_SEED, 'hFFC00, 0, 10));
        send_word(make_word(bpa_pkg::CMD_ALLOC, 0, 3, 0));        // split down
        send_word(make_word(bpa_pkg::CMD_ALLOC, 0, 1024, 0));
        send_word(make_word(bpa_pkg::CMD_FREE, 6, 2, 0));         // aligned free at order 1
        send_word(make_word(bpa_pkg::CMD_FREE, 0, 4, 0));         // free of page 0 at order 2
        send_word(make_word(bpa_pkg::CMD_FREE, 'hFFC00, 1024, 0));
        send_word(make_word(bpa_pkg::CMD_FREE, 'h400, 1024, 0));  // top order stops merge
        send_word(make_word(bpa_pkg::CMD_SEED, 'hFFFFF, 0, 0));
        send_word(make_word(bpa_pkg::CMD_ALLOC, 0, 'h7FF & 'h555, 0));
    endtask

    task automatic test_pool_full();
        // fill the pool with order-0 seeds, then push past it
        for (int i = 0; i < POOL + 4; i++)
            send_word(make_word(bpa_pkg::CMD_SEED, i * 2, 0, 0));
        send_word(make_word(bpa_pkg::CMD_ALLOC, 0, 2, 0));
        send_word(make_word(bpa_pkg::CMD_FREE, 'h80000, 16, 0));
        send_word(make_word(bpa_pkg::CMD_ALLOC, 0, 2, 0));
        // free order-1 blocks at multiples of four pages
        for (int i = 0; i < 40; i++)
            send_word(make_word(bpa_pkg::CMD_FREE, i * 4, 2, 0));
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_word(make_word(bpa_pkg::CMD_SEED, 'h40000 + i * 16, 0, 4));
        join
    endtask

    task automatic test_random(int n);
        bpa_pkg::in_word_t w;
        int o;
        for (int i = 0; i < n; i++) begin
            o = $urandom_range(0, 10);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    w = make_word(bpa_pkg::CMD_ALLOC, $urandom,
                                  $urandom_range(2, 1 << o), 0);
                end
                3, 4, 5: begin
                    w = make_word(bpa_pkg::CMD_FREE, ($urandom_range(0, 'hFFFFF) >> o) << o,
                                  (1 << o) - $urandom_range(0, (1 << o) / 2), 0);
                end
                6, 7: begin
                    w = make_word(bpa_pkg::CMD_SEED, ($urandom_range(0, 'hFFF) >> o) << o,
                                  $urandom, o);
                end
                default: begin
                    w = bpa_pkg::in_word_t'({$urandom, 5'($urandom)});
                    w.page_index = bpa_pkg::PAGE_W'($urandom);
                end
            endcase
            send_word(w);
        end
    endtask

    initial begin
        fail_count = 0;
        result_count = 0;
        quiet_mode = 1'b0;
        hold_off = 1'b0;
        valid_hi = 1'b0;
        foreach (status_seen[i]) status_seen[i] = 0;
        for (int i = 0; i < POOL; i++) begin
            sh_link[i] = i + 1;
            sh_page[i] = '0;
        end
        foreach (sh_head[i]) sh_head[i] = NIL;
        sh_pool = 0;
        sh_enabled = 1'b0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_disabled();
        test_directed();
        test_backpressure();
        test_random(80);
        write_enable(1'b0);
        test_disabled();
        write_enable(1'b1);
        test_pool_full();
        quiet_mode = 1'b1;
        test_random(60);
        drop_valid();

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Covered %0d results: ok %0d, bypass %0d, no-block %0d, invalid %0d,",
                 result_count, status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3]);
        $display("disabled %0d, pool-full %0d, with a long receiver hold-off.",
                 status_seen[4], status_seen[5]);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
